// ===== rtl/bpoq_pkg.sv =====
// ---------------------------------------------------------------------------
// bpoq_pkg: shared definitions for the bounded priority-ordered queue
// Opcodes and the control bundle that the top level sends to every cell.
// ---------------------------------------------------------------------------
package bpoq_pkg;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_STATUS = 2'd3
  } opcode_t;

  // Per-cycle command broadcast to the cell row
  typedef struct packed {
    logic insert_en;   // shift right behind the insert point, load the key
    logic remove_en;   // shift left from the first match onward
  } cell_ctrl_t;

endpackage

// ===== rtl/bpoq_cell.sv =====
// ---------------------------------------------------------------------------
// bpoq_cell: one slot of the sorted queue
// Holds one entry and compares it with the key. On insert it takes the key or
// its left neighbor's entry; on remove it takes its right neighbor's entry.
// ---------------------------------------------------------------------------
module bpoq_cell #(
  parameter int DW = 32,
  parameter int TW = 8,
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpoq_pkg::cell_ctrl_t ctrl,
  input  logic [DW-1:0]        key_data,
  input  logic [TW-1:0]        key_type,
  input  logic [PW-1:0]        key_prio,
  // left neighbor (closer to the head)
  input  logic                 left_valid,
  input  logic                 left_stay,
  input  logic [DW-1:0]        left_data,
  input  logic [TW-1:0]        left_type,
  input  logic [PW-1:0]        left_prio,
  // right neighbor (closer to the tail)
  input  logic                 right_valid,
  input  logic [DW-1:0]        right_data,
  input  logic [TW-1:0]        right_type,
  input  logic [PW-1:0]        right_prio,
  // first-match ripple
  input  logic                 seen_in,
  output logic                 seen_out,
  // current contents
  output logic                 valid,
  output logic                 stay,
  output logic [DW-1:0]        data,
  output logic [TW-1:0]        etype,
  output logic [PW-1:0]        prio,
  // contents after this cycle
  output logic                 valid_next,
  output logic [DW-1:0]        data_next,
  output logic [TW-1:0]        etype_next,
  output logic [PW-1:0]        prio_next
);
  import bpoq_pkg::*;

  logic match;

  // Compare against the key
  assign match    = valid && (data == key_data);
  assign seen_out = seen_in | match;
  assign stay     = valid && (prio >= key_prio);

  // Next contents
  always_comb begin
    valid_next = valid;
    data_next  = data;
    etype_next = etype;
    prio_next  = prio;
    if (ctrl.insert_en) begin
      valid_next = valid | left_valid;
      if (!stay) begin
        if (left_stay) begin
          data_next  = key_data;
          etype_next = key_type;
          prio_next  = key_prio;
        end else begin
          data_next  = left_data;
          etype_next = left_type;
          prio_next  = left_prio;
        end
      end
    end else if (ctrl.remove_en && seen_out) begin
      valid_next = right_valid;
      data_next  = right_data;
      etype_next = right_type;
      prio_next  = right_prio;
    end
  end

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    data  <= data_next;
    etype <= etype_next;
    prio  <= prio_next;
  end

endmodule

// ===== rtl/bounded_priority_ordered_queue_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_priority_ordered_queue_unit: sorted priority queue on a cell row
// Entries are kept in descending priority, older first among equals.
// Insert, search by data, remove by data and status; each item yields one
// result with ok, the count and the head entry.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   in       | in_valid/in_stall  | opcode, item_data, item_type, item_priority
//   out      | out_valid/out_stall| ok, entry_count, head_*
//   cfg      | cfg_wr_en          | cfg_wr_data (capacity limit)
//
// One item per cycle while in_stall is low; the result is registered and appears in the cycle after acceptance.
// All cells compare and shift in parallel; the first-match ripple through
// the row sets the clock period for search and remove.
// Reset clears the count and all slot flags.
// in_stall follows out_stall while a result is held in the output register.
// ---------------------------------------------------------------------------
module bounded_priority_ordered_queue_unit #(
  parameter int DEPTH          = 16,
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 8,
  parameter int TYPE_WIDTH     = 8,
  localparam int CW            = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [CW-1:0]             cfg_wr_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [DATA_WIDTH-1:0]     item_data,
  input  logic [TYPE_WIDTH-1:0]     item_type,
  input  logic [PRIORITY_WIDTH-1:0] item_priority,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic [CW-1:0]             entry_count,
  output logic                      head_valid,
  output logic [DATA_WIDTH-1:0]     head_data,
  output logic [TYPE_WIDTH-1:0]     head_type,
  output logic [PRIORITY_WIDTH-1:0] head_priority
);
  import bpoq_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0] capacity_limit;
  logic [CW-1:0] held_count;
  logic [CW-1:0] held_count_next;
  logic [CW-1:0] limit_eff;
  logic          full;
  logic          in_accept;
  logic          found;
  logic          ok_next;
  cell_ctrl_t    ctrl;

  logic [DEPTH-1:0]          valid_vec;
  logic [DEPTH-1:0]          stay_vec;
  logic [DEPTH:0]            seen;
  logic [DATA_WIDTH-1:0]     data_arr  [DEPTH];
  logic [TYPE_WIDTH-1:0]     type_arr  [DEPTH];
  logic [PRIORITY_WIDTH-1:0] prio_arr  [DEPTH];
  logic [DEPTH-1:0]          vnext_vec;
  logic [DATA_WIDTH-1:0]     dnext_arr [DEPTH];
  logic [TYPE_WIDTH-1:0]     tnext_arr [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pnext_arr [DEPTH];

  // Capacity limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= '0;
    end else if (cfg_wr_en) begin
      capacity_limit <= cfg_wr_data;
    end
  end

  // Limit of zero or beyond the row means the full row
  assign limit_eff = ((capacity_limit == '0) || (capacity_limit > DEPTH_C)) ?
                     DEPTH_C : capacity_limit;
  assign full      = (held_count >= limit_eff);

  // Handshake
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Commands to the row
  assign ctrl.insert_en = in_accept && (opcode == OP_INSERT) && !full;
  assign ctrl.remove_en = in_accept && (opcode == OP_REMOVE);

  // Cell row
  assign seen[0] = 1'b0;
  assign found   = seen[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_valid;
    logic                      l_stay;
    logic [DATA_WIDTH-1:0]     l_data;
    logic [TYPE_WIDTH-1:0]     l_type;
    logic [PRIORITY_WIDTH-1:0] l_prio;
    logic                      r_valid;
    logic [DATA_WIDTH-1:0]     r_data;
    logic [TYPE_WIDTH-1:0]     r_type;
    logic [PRIORITY_WIDTH-1:0] r_prio;

    // The head's left side acts as a held entry that always stays
    if (i == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_stay  = 1'b1;
      assign l_data  = item_data;
      assign l_type  = item_type;
      assign l_prio  = item_priority;
    end else begin : g_mid
      assign l_valid = valid_vec[i-1];
      assign l_stay  = stay_vec[i-1];
      assign l_data  = data_arr[i-1];
      assign l_type  = type_arr[i-1];
      assign l_prio  = prio_arr[i-1];
    end

    // Past the tail there is nothing to pull in
    if (i == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_data  = '0;
      assign r_type  = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = valid_vec[i+1];
      assign r_data  = data_arr[i+1];
      assign r_type  = type_arr[i+1];
      assign r_prio  = prio_arr[i+1];
    end

    bpoq_cell #(
      .DW (DATA_WIDTH),
      .TW (TYPE_WIDTH),
      .PW (PRIORITY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key_data    (item_data),
      .key_type    (item_type),
      .key_prio    (item_priority),
      .left_valid  (l_valid),
      .left_stay   (l_stay),
      .left_data   (l_data),
      .left_type   (l_type),
      .left_prio   (l_prio),
      .right_valid (r_valid),
      .right_data  (r_data),
      .right_type  (r_type),
      .right_prio  (r_prio),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .valid       (valid_vec[i]),
      .stay        (stay_vec[i]),
      .data        (data_arr[i]),
      .etype       (type_arr[i]),
      .prio        (prio_arr[i]),
      .valid_next  (vnext_vec[i]),
      .data_next   (dnext_arr[i]),
      .etype_next  (tnext_arr[i]),
      .prio_next   (pnext_arr[i])
    );
  end

  // Count and ok flag
  always_comb begin
    held_count_next = held_count;
    ok_next         = 1'b0;
    case (opcode)
      OP_INSERT: begin
        ok_next = !full;
        if (ctrl.insert_en) held_count_next = held_count + CW'(1);
      end
      OP_SEARCH: begin
        ok_next = found;
      end
      OP_REMOVE: begin
        ok_next = found;
        if (ctrl.remove_en && found) held_count_next = held_count - CW'(1);
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (in_accept) begin
      held_count <= held_count_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, head taken from cell 0 after the update
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ok          <= ok_next;
      entry_count <= held_count_next;
      head_valid  <= vnext_vec[0];
      if (vnext_vec[0]) begin
        head_data     <= dnext_arr[0];
        head_type     <= tnext_arr[0];
        head_priority <= pnext_arr[0];
      end else begin
        head_data     <= '0;
        head_type     <= '0;
        head_priority <= '0;
      end
    end
  end

  // Slot flags always match the count
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(held_count))
    else $error("slot flags disagree with held count");

  // Held entries are packed toward the head
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("gap in the occupied slots");

  // A refused insert leaves the count alone
  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (opcode == OP_INSERT) && full) |=> (held_count == $past(held_count)))
    else $error("insert into a full queue changed the count");

  // Count never exceeds the row
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= DEPTH_C)
    else $error("held count beyond depth");

endmodule
